// ----- design/bmg_pkg.sv -----
package bmg_pkg;

	// input mapping and scaling constants
	localparam logic [31:0] MASK32      = 32'hFFFF_FFFF;
	localparam logic [8:0]  U1_FLOOR    = 9'd430;
	localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
	localparam logic [30:0] HALFPI_Q30  = 31'd1686629713;

	// pipeline depths
	localparam int LOG_STEPS  = 30;
	localparam int SQRT_STEPS = 27;
	localparam int COS_TERMS  = 6;
	localparam int LAT_RAD    = 3 + LOG_STEPS + 2 + SQRT_STEPS;
	localparam int LAT_COS    = 3 + 3 * COS_TERMS + 2;

	// Horner denominators of the cosine series, with reciprocals for n / d
	localparam logic [7:0] COS_DEN [COS_TERMS] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12};
	localparam int COS_SHIFT [COS_TERMS] = '{39, 39, 38, 37, 36, 35};
	localparam logic [31:0] COS_MUL [COS_TERMS] = '{
		32'((64'd1 << 39) / 64'd182),
		32'((64'd1 << 39) / 64'd132),
		32'((64'd1 << 38) / 64'd90),
		32'((64'd1 << 37) / 64'd56),
		32'((64'd1 << 36) / 64'd30),
		32'((64'd1 << 35) / 64'd12)
	};

	typedef logic [26:0] radius_t;  // sqrt(-2 ln u1), Q.24
	typedef logic [30:0] cosv_t;    // |cos|, Q.30

	typedef struct packed {
		logic signed [31:0] mean;
		logic [30:0]        sigma;
	} side_t;

	typedef struct packed {
		cosv_t cos_val;
		logic  neg;
	} angle_t;

endpackage

// ----- design/bmg_radius.sv -----
module bmg_radius (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [31:0]      rand_word_a,
	output logic             out_valid,
	output bmg_pkg::radius_t radius
);
	import bmg_pkg::*;

	logic [LAT_RAD-1:0] vld_q;

	logic [63:0] prod_s1;
	logic [32:0] u1_s2;
	logic [30:0] m_s3;
	logic [4:0]  ip_s3;

	logic [30:0] lm_s  [LOG_STEPS];
	logic [29:0] lf_s  [LOG_STEPS];
	logic [4:0]  lip_s [LOG_STEPS];

	logic [46:0] pl_s34;
	logic [45:0] ph_s34;
	logic [35:0] t_s35;

	logic [53:0] sv_s [SQRT_STEPS];
	logic [53:0] sr_s [SQRT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT_RAD-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[LAT_RAD-1];

	// a * (2^32 - 430)
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {rand_word_a, 32'd0} - {23'd0, {9'd0, rand_word_a} * {32'd0, U1_FLOOR}};
		end
	end

	// divide by 2^32-1: q = h + floor((h + l) / (2^32-1)), then add the floor
	logic [32:0] hl_sum;
	logic [32:0] div_q;
	always_comb begin
		hl_sum = {1'b0, prod_s1[63:32]} + {1'b0, prod_s1[31:0]};
		div_q  = {1'b0, prod_s1[63:32]};
		if (hl_sum >= {MASK32, 1'b0}) begin
			div_q = div_q + 33'd2;
		end else if (hl_sum >= {1'b0, MASK32}) begin
			div_q = div_q + 33'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u1_s2 <= div_q + {24'd0, U1_FLOOR};
		end
	end

	// leading one and normalization to Q1.30
	logic [5:0]  lead;
	logic [30:0] norm;
	always_comb begin
		lead = '0;
		for (int k = 0; k < 33; k++) begin
			if (u1_s2[k]) begin
				lead = 6'(k);
			end
		end
		if (lead >= 6'd30) begin
			norm = 31'(u1_s2 >> (lead - 6'd30));
		end else begin
			norm = 31'(u1_s2 << (6'd30 - lead));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3  <= norm;
			ip_s3 <= 5'(6'd32 - lead);
		end
	end

	// one fraction bit of log2 per stage by squaring
	for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
		logic [30:0] m_in;
		logic [29:0] f_in;
		logic [4:0]  ip_in;
		logic [61:0] sq;
		if (i == 0) begin : g_first
			assign m_in  = m_s3;
			assign f_in  = '0;
			assign ip_in = ip_s3;
		end else begin : g_next
			assign m_in  = lm_s[i-1];
			assign f_in  = lf_s[i-1];
			assign ip_in = lip_s[i-1];
		end
		assign sq = {31'd0, m_in} * {31'd0, m_in};
		always_ff @(posedge clk) begin
			if (en) begin
				if (sq[61]) begin
					lm_s[i] <= sq[61:31];
					lf_s[i] <= {f_in[28:0], 1'b1};
				end else begin
					lm_s[i] <= sq[60:30];
					lf_s[i] <= {f_in[28:0], 1'b0};
				end
				lip_s[i] <= ip_in;
			end
		end
	end

	// -log2 u1 times 2 ln 2, in two partial products
	logic [34:0] nlog;
	assign nlog = {lip_s[LOG_STEPS-1], 30'd0} - {5'd0, lf_s[LOG_STEPS-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s34 <= {29'd0, nlog[17:0]} * {18'd0, TWO_LN2_Q28};
			ph_s34 <= {29'd0, nlog[34:18]} * {17'd0, TWO_LN2_Q28};
		end
	end

	// t reaches just above 32 at the smallest u1, so it keeps six integer bits
	logic [63:0] t_full;
	assign t_full = {ph_s34, 18'd0} + {17'd0, pl_s34} + 64'd134217728;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s35 <= t_full[63:28];
		end
	end

	// restoring square root, one result bit per stage
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [53:0] BIT = 54'd1 << (52 - 2 * k);
		logic [53:0] v_in;
		logic [53:0] r_in;
		logic [54:0] trial;
		if (k == 0) begin : g_first
			assign v_in = {t_s35, 18'd0};
			assign r_in = '0;
		end else begin : g_next
			assign v_in = sv_s[k-1];
			assign r_in = sr_s[k-1];
		end
		assign trial = {1'b0, r_in} + {1'b0, BIT};
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, v_in} >= trial) begin
					sv_s[k] <= v_in - trial[53:0];
					sr_s[k] <= (r_in >> 1) + BIT;
				end else begin
					sv_s[k] <= v_in;
					sr_s[k] <= r_in >> 1;
				end
			end
		end
	end

	assign radius = sr_s[SQRT_STEPS-1][26:0];

endmodule

// ----- design/bmg_cosine.sv -----
module bmg_cosine (
	input  logic            clk,
	input  logic            en,
	input  logic [31:0]     rand_word_b,
	output bmg_pkg::angle_t angle
);
	import bmg_pkg::*;

	localparam int PAD = LAT_RAD - LAT_COS;

	logic [30:0] p_s1;
	logic [30:0] x_s2;
	logic [31:0] x2_s3;
	logic [LAT_RAD-1:0] ng_q;

	logic [31:0] na_s  [COS_TERMS];
	logic [31:0] xa_s  [COS_TERMS];
	logic [31:0] qb_s  [COS_TERMS];
	logic [31:0] nb_s  [COS_TERMS];
	logic [31:0] xb_s  [COS_TERMS];
	logic [30:0] acc_s [COS_TERMS];
	logic [31:0] xc_s  [COS_TERMS];

	logic [31:0] tt_sf1;
	cosv_t       c_sf2;
	cosv_t       pad_q [PAD];

	// fold the turn count into a quarter turn
	logic [31:0] p0;
	logic [32:0] p1;
	logic [30:0] p2;
	logic        neg;
	always_comb begin
		p0 = (rand_word_b == MASK32) ? 32'd0 : rand_word_b;
		if ({1'b0, p0} > 33'h0_8000_0000) begin
			p1 = 33'h1_0000_0000 - {1'b0, p0};
		end else begin
			p1 = {1'b0, p0};
		end
		neg = (p1 > 33'h0_4000_0000);
		if (neg) begin
			p2 = 31'(33'h0_8000_0000 - p1);
		end else begin
			p2 = p1[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p2;
			ng_q <= {ng_q[LAT_RAD-2:0], neg};
		end
	end

	logic [61:0] xp;
	assign xp = {31'd0, p_s1} * {31'd0, HALFPI_Q30} + 62'd536870912;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= xp[60:30];
		end
	end

	logic [61:0] xsq;
	assign xsq = {31'd0, x_s2} * {31'd0, x_s2} + 62'd536870912;

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s3 <= xsq[61:30];
		end
	end

	// Horner terms: multiply, reciprocal divide, correct and subtract
	for (genvar j = 0; j < COS_TERMS; j++) begin : g_term
		logic [30:0] acc_in;
		logic [31:0] x2_in;
		logic [62:0] pa;
		logic [63:0] pb;
		logic [39:0] pc;
		logic [39:0] rem;
		logic        fix;
		if (j == 0) begin : g_first
			assign acc_in = 31'h4000_0000;
			assign x2_in  = x2_s3;
		end else begin : g_next
			assign acc_in = acc_s[j-1];
			assign x2_in  = xc_s[j-1];
		end
		assign pa  = {31'd0, x2_in} * {32'd0, acc_in};
		assign pb  = {32'd0, na_s[j]} * {32'd0, COS_MUL[j]};
		assign pc  = {8'd0, qb_s[j]} * {32'd0, COS_DEN[j]};
		assign rem = {8'd0, nb_s[j]} - pc;
		assign fix = (rem >= {32'd0, COS_DEN[j]});
		always_ff @(posedge clk) begin
			if (en) begin
				na_s[j]  <= pa[61:30];
				xa_s[j]  <= x2_in;
				qb_s[j]  <= 32'(pb >> COS_SHIFT[j]);
				nb_s[j]  <= na_s[j];
				xb_s[j]  <= xa_s[j];
				acc_s[j] <= 31'(32'h4000_0000 - qb_s[j] - {31'd0, fix});
				xc_s[j]  <= xb_s[j];
			end
		end
	end

	logic [62:0] pf;
	assign pf = {31'd0, xc_s[COS_TERMS-1]} * {32'd0, acc_s[COS_TERMS-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			tt_sf1 <= pf[62:31];
			// a value just past one near a quarter turn clamps to zero
			c_sf2  <= (tt_sf1 >= 32'h4000_0000) ? '0 : 31'(32'h4000_0000 - tt_sf1);
		end
	end

	// align with the radius path
	always_ff @(posedge clk) begin
		if (en) begin
			pad_q[0] <= c_sf2;
			for (int i = 1; i < PAD; i++) begin
				pad_q[i] <= pad_q[i-1];
			end
		end
	end

	assign angle.cos_val = pad_q[PAD-1];
	assign angle.neg     = ng_q[LAT_RAD-1];

endmodule

// ----- design/box_muller_gaussian_sample_top.sv -----
// Box-Muller Gaussian sample generator, Q16.16. Each transfer in carries two
// uniform words, a mean and a standard deviation; each transfer out carries
// mean + std_dev * sqrt(-2 ln u1) * cos(2 pi u2), saturated to the signed
// 32-bit range with saturated_flag set when clipped. The block is a fully
// pipelined datapath: it takes one item per clock and returns one sample per
// clock while the output is not held. The radius path sets the depth: the
// u1 product, u1 and normalized mantissa registers, 30 squaring stages for
// the log2 fraction bits, the ln partial-product and sum registers, 27
// square-root stages, then the r * cos, sigma-product and saturated-sum
// registers. The cosine path runs alongside and is delay-matched. When the
// output is held (out_valid high, out_ready low) every stage freezes, so
// in_ready drops in the same cycle; nothing is lost or repeated. No
// configuration, no state between items.
module box_muller_gaussian_sample_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        rand_word_a,
	input  logic [31:0]        rand_word_b,
	input  logic signed [31:0] mean_value,
	input  logic [30:0]        std_dev,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] gauss_sample,
	output logic               saturated_flag
);
	import bmg_pkg::*;

	// global advance: the whole pipe moves unless the output is stuck
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic    rad_valid;
	radius_t radius;
	angle_t  angle;

	bmg_radius u_radius (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.rand_word_a(rand_word_a),
		.out_valid  (rad_valid),
		.radius     (radius)
	);

	bmg_cosine u_cosine (
		.clk        (clk),
		.en         (en),
		.rand_word_b(rand_word_b),
		.angle      (angle)
	);

	// mean and sigma ride along with the radius path
	side_t side_q [LAT_RAD];
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= '{mean: mean_value, sigma: std_dev};
			for (int i = 1; i < LAT_RAD; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// |z| = r * cos, Q.30
	logic        v_s1, v_s2, out_valid_q;
	logic [33:0] z_s1;
	side_t       side_s1, side_s2;
	logic        neg_s1, neg_s2;
	logic [34:0] dev_s2;
	logic signed [31:0] sample_q;
	logic        sat_q;

	logic [57:0] zp;
	assign zp = {31'd0, radius} * {27'd0, angle.cos_val} + 58'd8388608;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= zp[57:24];
			side_s1 <= side_q[LAT_RAD-1];
			neg_s1  <= angle.neg;
		end
	end

	// deviation = sigma * |z|, Q16.16
	logic [64:0] dp;
	assign dp = {34'd0, side_s1.sigma} * {31'd0, z_s1} + 65'd536870912;

	always_ff @(posedge clk) begin
		if (en) begin
			dev_s2  <= dp[64:30];
			side_s2 <= side_s1;
			neg_s2  <= neg_s1;
		end
	end

	// signed sum with saturation
	logic signed [36:0] sum;
	logic signed [31:0] clipped;
	logic               clip;
	always_comb begin
		if (neg_s2) begin
			sum = 37'($signed(side_s2.mean)) - $signed({2'b0, dev_s2});
		end else begin
			sum = 37'($signed(side_s2.mean)) + $signed({2'b0, dev_s2});
		end
		clip    = 1'b0;
		clipped = sum[31:0];
		if (sum > 37'sh0_7FFF_FFFF) begin
			clipped = 32'sh7FFF_FFFF;
			clip    = 1'b1;
		end else if (sum < -37'sh0_8000_0000) begin
			clipped = 32'sh8000_0000;
			clip    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_q <= clipped;
			sat_q    <= clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= rad_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	assign out_valid      = out_valid_q;
	assign gauss_sample   = sample_q;
	assign saturated_flag = sat_q;

endmodule
